@@ rtl/cmc_pkg.sv @@
// shared types and constants of the three-c miss classifier
package cmc_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned WAYS_DEF      = 4;
  localparam int unsigned SETS_DEF      = 16;

  localparam int unsigned TS_W       = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned LFSR_W     = 16;
  localparam int unsigned SEEN_ROW_W = 64;
  localparam int unsigned SEEN_BIT_W = 6;
  localparam int unsigned MOD_DW     = 9;
  localparam int unsigned POL_W      = 2;
  localparam int unsigned OFS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned NUM_STATS  = 5;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'd1;

  localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POL_W-1:0] POL_LRU  = 2'd1;

  localparam logic [POL_W-1:0] POL_RESET = POL_LRU;
  localparam logic [OFS_W-1:0] OFS_RESET = 4'd4;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_COMP = 2'd1,
    KIND_CAP  = 2'd2,
    KIND_CONF = 2'd3
  } kind_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clr;
    logic start;
    logic mod_load;
    logic mod_sel_lfsr;
    logic set_cap;
    logic seen_rd;
    logic seen_wr;
    logic sh_rd;
    logic sh_cmp;
    logic sh_upd;
    logic way_rd;
    logic way_cmp;
    logic lfsr_adv;
    logic way_upd;
    logic fin;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clr_done;
    logic mod_busy;
    logic sh_empty;
    logic sh_last;
    logic way_last;
    logic need_rand;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/cmc_if.sv @@
// request and result channel interfaces
interface cmc_req_if #(
  parameter int unsigned ADDR_BITS = cmc_pkg::ADDR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface cmc_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               access_kind;
  logic [cmc_pkg::CNT_W-1:0] total_count;
  logic [cmc_pkg::CNT_W-1:0] hit_count;
  logic [cmc_pkg::CNT_W-1:0] compulsory_count;
  logic [cmc_pkg::CNT_W-1:0] capacity_count;
  logic [cmc_pkg::CNT_W-1:0] conflict_count;

  modport source (output valid, output access_kind, output total_count, output hit_count,
                  output compulsory_count, output capacity_count, output conflict_count,
                  input ready);
  modport sink   (input valid, input access_kind, input total_count, input hit_count,
                  input compulsory_count, input capacity_count, input conflict_count,
                  output ready);
endinterface

@@ rtl/cmc_mod_unit.sv @@
// remainder by one of two constant divisors through reciprocal multiplication
module cmc_mod_unit #(
  parameter int unsigned MW = 16,
  parameter int unsigned D0 = 16,
  parameter int unsigned D1 = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       sel_i,
  input  logic [MW-1:0]              operand_i,
  output logic                       busy_o,
  output logic [cmc_pkg::MOD_DW-1:0] rem_o
);
  localparam int unsigned L0 = (D0 > 1) ? $clog2(D0) : 0;
  localparam int unsigned L1 = (D1 > 1) ? $clog2(D1) : 0;
  localparam int unsigned S0 = MW + L0;
  localparam int unsigned S1 = MW + L1;
  localparam int unsigned PW = 2 * MW + 1;
  // rounded-up reciprocals, exact quotient for every operand below 2**MW
  localparam logic [63:0] M0_FULL = ((64'd1 << S0) + 64'(D0) - 64'd1) / 64'(D0);
  localparam logic [63:0] M1_FULL = ((64'd1 << S1) + 64'(D1) - 64'd1) / 64'(D1);
  localparam logic [MW:0] M0 = M0_FULL[MW:0];
  localparam logic [MW:0] M1 = M1_FULL[MW:0];

  logic [1:0]                 cnt_q, cnt_d;
  logic [MW-1:0]              op_q;
  logic                       sel_q;
  logic [PW-1:0]              prod_q;
  logic [cmc_pkg::MOD_DW-1:0] rem_q;
  logic [MW:0]                mult;
  logic [MW-1:0]              quot;
  logic [cmc_pkg::MOD_DW-1:0] qd;

  assign mult = sel_q ? M1 : M0;
  assign quot = sel_q ? MW'(prod_q >> S1) : MW'(prod_q >> S0);
  assign qd   = quot[cmc_pkg::MOD_DW-1:0] *
                (sel_q ? cmc_pkg::MOD_DW'(D1) : cmc_pkg::MOD_DW'(D0));

  always_comb begin
    cnt_d = cnt_q;
    if (load_i) begin
      cnt_d = 2'd2;
    end else if (cnt_q != 2'd0) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // load, then multiply, then subtract quotient times divisor
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q  <= operand_i;
      sel_q <= sel_i;
    end
    if (cnt_q == 2'd2) prod_q <= PW'(op_q) * PW'(mult);
    if (cnt_q == 2'd1) rem_q <= op_q[cmc_pkg::MOD_DW-1:0] - qd;
  end

  assign busy_o = (cnt_q != 2'd0);
  assign rem_o  = rem_q;
endmodule

@@ rtl/cmc_ctrl.sv @@
// sequencing state machine of the classifier
module cmc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cmc_pkg::sts_t sts_i,
  output cmc_pkg::cmd_t cmd_o
);
  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_MOD_LD  = 16'h0004,
    S_MOD_WT  = 16'h0008,
    S_SEEN_RD = 16'h0010,
    S_SEEN_WR = 16'h0020,
    S_SH_RD   = 16'h0040,
    S_SH_CMP  = 16'h0080,
    S_SH_UPD  = 16'h0100,
    S_WAY_RD  = 16'h0200,
    S_WAY_CMP = 16'h0400,
    S_WAY_DEC = 16'h0800,
    S_RAND_LD = 16'h1000,
    S_RAND_WT = 16'h2000,
    S_WAY_UPD = 16'h4000,
    S_DONE    = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_MOD_LD;
        end
      end
      S_MOD_LD: begin
        cmd_o.mod_load = 1'b1;
        state_d        = S_MOD_WT;
      end
      S_MOD_WT: begin
        if (!sts_i.mod_busy) state_d = S_SEEN_RD;
      end
      S_SEEN_RD: begin
        cmd_o.set_cap = 1'b1;
        cmd_o.seen_rd = 1'b1;
        state_d       = S_SEEN_WR;
      end
      S_SEEN_WR: begin
        cmd_o.seen_wr = 1'b1;
        state_d       = sts_i.sh_empty ? S_SH_UPD : S_SH_RD;
      end
      S_SH_RD: begin
        cmd_o.sh_rd = 1'b1;
        state_d     = S_SH_CMP;
      end
      S_SH_CMP: begin
        cmd_o.sh_cmp = 1'b1;
        state_d      = sts_i.sh_last ? S_SH_UPD : S_SH_RD;
      end
      S_SH_UPD: begin
        cmd_o.sh_upd = 1'b1;
        state_d      = S_WAY_RD;
      end
      S_WAY_RD: begin
        cmd_o.way_rd = 1'b1;
        state_d      = S_WAY_CMP;
      end
      S_WAY_CMP: begin
        cmd_o.way_cmp = 1'b1;
        if (sts_i.way_last) state_d = S_WAY_DEC;
      end
      S_WAY_DEC: begin
        if (sts_i.need_rand) begin
          cmd_o.lfsr_adv = 1'b1;
          state_d        = S_RAND_LD;
        end else begin
          state_d = S_WAY_UPD;
        end
      end
      S_RAND_LD: begin
        cmd_o.mod_load     = 1'b1;
        cmd_o.mod_sel_lfsr = 1'b1;
        state_d            = S_RAND_WT;
      end
      S_RAND_WT: begin
        if (!sts_i.mod_busy) state_d = S_WAY_UPD;
      end
      S_WAY_UPD: begin
        cmd_o.way_upd = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
endmodule

@@ rtl/cmc_dp.sv @@
// datapath: stores, scans, counters and result register
module cmc_dp #(
  parameter int unsigned ADDR_BITS = cmc_pkg::ADDR_BITS_DEF,
  parameter int unsigned WAYS      = cmc_pkg::WAYS_DEF,
  parameter int unsigned SETS      = cmc_pkg::SETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cmc_pkg::cmd_t                  cmd_i,
  output cmc_pkg::sts_t                  sts_o,
  input  logic [ADDR_BITS-1:0]           address_i,
  input  logic                           cfg_we_i,
  input  logic [cmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [1:0]                     access_kind_o,
  output logic [cmc_pkg::CNT_W-1:0]      total_count_o,
  output logic [cmc_pkg::CNT_W-1:0]      hit_count_o,
  output logic [cmc_pkg::CNT_W-1:0]      compulsory_count_o,
  output logic [cmc_pkg::CNT_W-1:0]      capacity_count_o,
  output logic [cmc_pkg::CNT_W-1:0]      conflict_count_o
);
  localparam int unsigned AW      = ADDR_BITS;
  localparam int unsigned TW      = cmc_pkg::TS_W;
  localparam int unsigned CW      = cmc_pkg::CNT_W;
  localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned VC_W    = $clog2(WAYS + 1);
  localparam int unsigned WC_W    = $clog2(WAYS + 1);
  localparam int unsigned SH_N    = SETS * WAYS;
  localparam int unsigned SH_W    = (SH_N > 1) ? $clog2(SH_N) : 1;
  localparam int unsigned SH_CW   = $clog2(SH_N + 1);
  localparam int unsigned SEEN_IW = AW - cmc_pkg::SEEN_BIT_W;
  localparam int unsigned SEEN_R  = 2 ** SEEN_IW;
  localparam int unsigned MW      = (AW > cmc_pkg::LFSR_W) ? AW : cmc_pkg::LFSR_W;

  // configuration
  logic [cmc_pkg::POL_W-1:0] policy_q;
  logic [cmc_pkg::OFS_W-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= cmc_pkg::POL_RESET;
      offset_q <= cmc_pkg::OFS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmc_pkg::CFG_POLICY: policy_q <= cfg_data_i[cmc_pkg::POL_W-1:0];
        cmc_pkg::CFG_OFFSET: policy_q <= policy_q;
        default: policy_q <= policy_q;
      endcase
      if (cfg_idx_i == cmc_pkg::CFG_OFFSET) offset_q <= cfg_data_i;
    end
  end

  // access state
  logic [AW-1:0]    blk_q;
  logic [TW-1:0]    clock_q;
  logic [SET_W-1:0] set_q;

  // shared modulo: set index, then random victim
  logic [cmc_pkg::LFSR_W-1:0] lfsr_q;
  logic                       mod_busy;
  logic [cmc_pkg::MOD_DW-1:0] mod_rem;
  logic [MW-1:0]              mod_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
    end else if (cmd_i.start) begin
      clock_q <= clock_q + TW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) blk_q <= address_i >> offset_q;
    if (cmd_i.set_cap) set_q <= mod_rem[SET_W-1:0];
  end

  assign mod_op = cmd_i.mod_sel_lfsr ? MW'(lfsr_q) : MW'(blk_q);

  cmc_mod_unit #(
    .MW (MW),
    .D0 (SETS),
    .D1 (WAYS)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (cmd_i.mod_load),
    .sel_i     (cmd_i.mod_sel_lfsr),
    .operand_i (mod_op),
    .busy_o    (mod_busy),
    .rem_o     (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= cmc_pkg::LFSR_SEED;
    end else if (cmd_i.lfsr_adv) begin
      lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? cmc_pkg::LFSR_TAPS : '0);
    end
  end

  // seen map, cleared by a sweep after reset
  logic [cmc_pkg::SEEN_ROW_W-1:0] seen_mem [SEEN_R];
  logic [cmc_pkg::SEEN_ROW_W-1:0] seen_row_q;
  logic [SEEN_IW:0]               clr_idx_q;
  logic                           first_seen_q;
  logic [SEEN_IW-1:0]             seen_addr;

  assign seen_addr = blk_q[AW-1:cmc_pkg::SEEN_BIT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr && !clr_idx_q[SEEN_IW]) begin
      clr_idx_q <= clr_idx_q + (SEEN_IW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr && !clr_idx_q[SEEN_IW]) begin
      seen_mem[clr_idx_q[SEEN_IW-1:0]] <= '0;
    end else if (cmd_i.seen_wr) begin
      seen_mem[seen_addr] <= seen_row_q |
        (cmc_pkg::SEEN_ROW_W'(1) << blk_q[cmc_pkg::SEEN_BIT_W-1:0]);
    end
    if (cmd_i.seen_rd) seen_row_q <= seen_mem[seen_addr];
    if (cmd_i.seen_wr) first_seen_q <= !seen_row_q[blk_q[cmc_pkg::SEEN_BIT_W-1:0]];
  end

  // shadow cache, fully associative lru; entries fill in order
  logic [AW-1:0]    sh_tag_mem [SH_N];
  logic [TW-1:0]    sh_use_mem [SH_N];
  logic [AW-1:0]    sh_rd_tag_q;
  logic [TW-1:0]    sh_rd_use_q;
  logic [SH_CW-1:0] sh_cnt_q;
  logic [SH_CW-1:0] sh_idx_q;
  logic             sh_hit_q;
  logic [SH_W-1:0]  sh_hit_idx_q;
  logic [SH_W-1:0]  sh_min_idx_q;
  logic [TW-1:0]    sh_min_q;
  logic [SH_W-1:0]  sh_wr_idx;

  always_comb begin
    if (sh_hit_q) begin
      sh_wr_idx = sh_hit_idx_q;
    end else if (sh_cnt_q != SH_CW'(SH_N)) begin
      sh_wr_idx = sh_cnt_q[SH_W-1:0];
    end else begin
      sh_wr_idx = sh_min_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_cnt_q <= '0;
    end else if (cmd_i.sh_upd && !sh_hit_q && sh_cnt_q != SH_CW'(SH_N)) begin
      sh_cnt_q <= sh_cnt_q + SH_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sh_idx_q <= '0;
      sh_hit_q <= 1'b0;
    end
    if (cmd_i.sh_rd) begin
      sh_rd_tag_q <= sh_tag_mem[sh_idx_q[SH_W-1:0]];
      sh_rd_use_q <= sh_use_mem[sh_idx_q[SH_W-1:0]];
    end
    if (cmd_i.sh_cmp) begin
      if (!sh_hit_q && sh_rd_tag_q == blk_q) begin
        sh_hit_q     <= 1'b1;
        sh_hit_idx_q <= sh_idx_q[SH_W-1:0];
      end
      if (sh_idx_q == '0 || sh_rd_use_q < sh_min_q) begin
        sh_min_q     <= sh_rd_use_q;
        sh_min_idx_q <= sh_idx_q[SH_W-1:0];
      end
      sh_idx_q <= sh_idx_q + SH_CW'(1);
    end
    if (cmd_i.sh_upd) begin
      sh_use_mem[sh_wr_idx] <= clock_q;
      if (!sh_hit_q) sh_tag_mem[sh_wr_idx] <= blk_q;
    end
  end

  // real cache rows, one row per set; ways fill in order
  logic [WAYS-1:0][AW-1:0] way_tag_mem  [SETS];
  logic [WAYS-1:0][TW-1:0] way_fill_mem [SETS];
  logic [WAYS-1:0][TW-1:0] way_use_mem  [SETS];
  logic [WAYS-1:0][AW-1:0] row_tag_q, row_tag_n;
  logic [WAYS-1:0][TW-1:0] row_fill_q, row_fill_n;
  logic [WAYS-1:0][TW-1:0] row_use_q, row_use_n;
  logic [VC_W-1:0]         vcnt_q [SETS];
  logic [VC_W-1:0]         vcnt_set;
  logic [WC_W-1:0]         w_q;
  logic                    w_hit_q;
  logic [WAY_W-1:0]        w_hit_idx_q;
  logic [WAY_W-1:0]        w_min_idx_q;
  logic [TW-1:0]           w_min_q;
  logic [TW-1:0]           w_ts;
  logic                    set_full;
  logic [WAY_W-1:0]        victim;

  assign vcnt_set = vcnt_q[set_q];
  assign set_full = (vcnt_set == VC_W'(WAYS));
  assign w_ts     = (policy_q == cmc_pkg::POL_FIFO) ? row_fill_q[w_q[WAY_W-1:0]]
                                                    : row_use_q[w_q[WAY_W-1:0]];

  always_comb begin
    if (!set_full) begin
      victim = vcnt_set[WAY_W-1:0];
    end else if (policy_q == cmc_pkg::POL_FIFO || policy_q == cmc_pkg::POL_LRU) begin
      victim = w_min_idx_q;
    end else begin
      victim = mod_rem[WAY_W-1:0];
    end
    row_tag_n  = row_tag_q;
    row_fill_n = row_fill_q;
    row_use_n  = row_use_q;
    if (w_hit_q) begin
      row_use_n[w_hit_idx_q] = clock_q;
    end else begin
      row_tag_n[victim]  = blk_q;
      row_fill_n[victim] = clock_q;
      row_use_n[victim]  = clock_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) vcnt_q[s] <= '0;
    end else if (cmd_i.way_upd && !w_hit_q && !set_full) begin
      vcnt_q[set_q] <= vcnt_set + VC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.way_rd) begin
      row_tag_q  <= way_tag_mem[set_q];
      row_fill_q <= way_fill_mem[set_q];
      row_use_q  <= way_use_mem[set_q];
      w_q        <= '0;
      w_hit_q    <= 1'b0;
    end
    if (cmd_i.way_cmp) begin
      if (!w_hit_q && VC_W'(w_q) < vcnt_set && row_tag_q[w_q[WAY_W-1:0]] == blk_q) begin
        w_hit_q     <= 1'b1;
        w_hit_idx_q <= w_q[WAY_W-1:0];
      end
      if (w_q == '0 || w_ts < w_min_q) begin
        w_min_q     <= w_ts;
        w_min_idx_q <= w_q[WAY_W-1:0];
      end
      w_q <= w_q + WC_W'(1);
    end
    if (cmd_i.way_upd) begin
      way_tag_mem[set_q]  <= row_tag_n;
      way_fill_mem[set_q] <= row_fill_n;
      way_use_mem[set_q]  <= row_use_n;
    end
  end

  // classification, statistics and result register
  cmc_pkg::kind_e kind_d, kind_q;
  logic [2:0]     kind_idx;
  logic [CW-1:0]  stat_q [cmc_pkg::NUM_STATS];
  logic           out_valid_q;

  // flags hold from the scans until the next request starts
  always_comb begin
    if (w_hit_q) kind_d = cmc_pkg::KIND_HIT;
    else if (first_seen_q) kind_d = cmc_pkg::KIND_COMP;
    else if (!sh_hit_q) kind_d = cmc_pkg::KIND_CAP;
    else kind_d = cmc_pkg::KIND_CONF;
  end

  assign kind_idx = {1'b0, kind_d} + 3'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) kind_q <= kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < cmc_pkg::NUM_STATS; k++) stat_q[k] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        if (stat_q[0] != '1) stat_q[0] <= stat_q[0] + CW'(1);
        if (stat_q[kind_idx] != '1) begin
          stat_q[kind_idx] <= stat_q[kind_idx] + CW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign access_kind_o      = kind_q;
  assign total_count_o      = stat_q[0];
  assign hit_count_o        = stat_q[1];
  assign compulsory_count_o = stat_q[2];
  assign capacity_count_o   = stat_q[3];
  assign conflict_count_o   = stat_q[4];

  assign sts_o.clr_done  = clr_idx_q[SEEN_IW];
  assign sts_o.mod_busy  = mod_busy;
  assign sts_o.sh_empty  = (sh_cnt_q == '0);
  assign sts_o.sh_last   = (sh_idx_q + SH_CW'(1) >= sh_cnt_q);
  assign sts_o.way_last  = (w_q == WC_W'(WAYS - 1));
  assign sts_o.need_rand = !w_hit_q && set_full &&
                           policy_q != cmc_pkg::POL_FIFO && policy_q != cmc_pkg::POL_LRU;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
endmodule

@@ rtl/cache_miss_classifier_3c.sv @@
// top level of the set-associative cache three-c miss classifier
// Each request carries one byte address; the block takes one request at a time and returns one
// result with the access kind (hit, compulsory, capacity or conflict miss) and five saturating
// running counts. Each valid shadow entry (up to SETS*WAYS) is read through its memory port and
// then compared, the set's ways are compared one per cycle, and the set index comes from a
// reciprocal-multiply modulo unit that loads, multiplies and subtracts; a pseudo-random
// eviction adds an lfsr step and another modulo pass. The next request can be taken in the
// cycle after the result is loaded, and loading waits while an earlier result is still held.
// After reset a clearing pass over the 2**ADDR_BITS/64 rows of the seen map wipes it, and no
// request is taken during it; registers should be written only while no request is in flight.
module cache_miss_classifier_3c #(
  parameter int unsigned ADDR_BITS = cmc_pkg::ADDR_BITS_DEF,
  parameter int unsigned WAYS      = cmc_pkg::WAYS_DEF,
  parameter int unsigned SETS      = cmc_pkg::SETS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cmc_req_if.sink                        req,
  cmc_rsp_if.source                      rsp,
  input  logic                           cfg_we_i,
  input  logic [cmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  cmc_pkg::cmd_t cmd;
  cmc_pkg::sts_t sts;

  // controller: sequences clear sweep, modulo, seen map, shadow scan, way scan, way update, result
  cmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: memories, counters, output register
  cmc_dp #(
    .ADDR_BITS (ADDR_BITS),
    .WAYS      (WAYS),
    .SETS      (SETS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .address_i          (req.address),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .out_ready_i        (rsp.ready),
    .out_valid_o        (rsp.valid),
    .access_kind_o      (rsp.access_kind),
    .total_count_o      (rsp.total_count),
    .hit_count_o        (rsp.hit_count),
    .compulsory_count_o (rsp.compulsory_count),
    .capacity_count_o   (rsp.capacity_count),
    .conflict_count_o   (rsp.conflict_count)
  );

`ifndef ASSERT_OFF
  // a result is only loaded when the output register can take it
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> sts.out_free) else $error("result loaded over a pending one");

  // after a result is loaded it is presented
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> rsp.valid) else $error("loaded result not presented");

  // no request taken during the clear sweep
  a_clr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !req.ready) else $error("request accepted during clear");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> !req.ready) else $error("second request accepted while busy");
`endif
endmodule

@@ tb/sv/cache_miss_classifier_3c_tb.sv @@
// self-checking testbench for the three-c cache miss classifier
module cache_miss_classifier_3c_tb;
  import cmc_pkg::*;

  localparam int unsigned NWAYS    = WAYS_DEF;
  localparam int unsigned NSETS    = SETS_DEF;
  localparam int unsigned NSHADOW  = NWAYS * NSETS;
  localparam int unsigned AW       = ADDR_BITS_DEF;
  // worst request: full shadow scan, way compare, two modulo passes, plus margin
  localparam int unsigned REQ_LAT  = 2 * NSHADOW + NWAYS + 2 * AW + 40;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam logic [POL_W-1:0] POL_RAND   = 2'd2;
  localparam logic [POL_W-1:0] POL_UNUSED = 2'd3;

  typedef struct packed {
    kind_e             kind;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  hits;
    logic [CNT_W-1:0]  compulsory;
    logic [CNT_W-1:0]  capacity;
    logic [CNT_W-1:0]  conflict;
  } outcome_t;

  // predicts the classification of each accepted request and checks results in order
  class miss_scoreboard;
    logic [POL_W-1:0]  policy;
    logic [OFS_W-1:0]  offset;
    logic              way_ok   [NSETS][NWAYS];
    logic [AW-1:0]     way_blk  [NSETS][NWAYS];
    logic [TS_W-1:0]   way_fill [NSETS][NWAYS];
    logic [TS_W-1:0]   way_used [NSETS][NWAYS];
    logic              sh_ok    [NSHADOW];
    logic [AW-1:0]     sh_blk   [NSHADOW];
    logic [TS_W-1:0]   sh_used  [NSHADOW];
    logic              seen     [1 << AW];
    logic [TS_W-1:0]   tick;
    logic [CNT_W-1:0]  stats    [NUM_STATS];
    logic [LFSR_W-1:0] lfsr;
    outcome_t          pending_q[$];
    int                mismatches;

    function new();
      policy = POL_RESET;
      offset = OFS_RESET;
      foreach (way_ok[s, w]) way_ok[s][w] = 1'b0;
      foreach (sh_ok[i]) begin
        sh_ok[i] = 1'b0;
        sh_used[i] = '0;
      end
      foreach (seen[i]) seen[i] = 1'b0;
      foreach (stats[i]) stats[i] = '0;
      tick = '0;
      lfsr = LFSR_SEED;
      mismatches = 0;
    endfunction

    function void bump(int k);
      if (stats[k] != '1) stats[k]++;
    endfunction

    // fully associative lru shadow; returns 1 on a shadow hit
    function bit shadow_lookup(logic [AW-1:0] blk);
      int victim;
      logic [TS_W-1:0] oldest;
      victim = 0;
      oldest = '0;
      for (int i = 0; i < NSHADOW; i++) begin
        if (sh_ok[i] && sh_blk[i] == blk) begin
          sh_used[i] = tick;
          return 1'b1;
        end
      end
      for (int i = 0; i < NSHADOW; i++) begin
        if (!sh_ok[i]) begin
          victim = i;
          break;
        end
        if (i == 0 || sh_used[i] < oldest) begin
          oldest = sh_used[i];
          victim = i;
        end
      end
      sh_ok[victim]   = 1'b1;
      sh_blk[victim]  = blk;
      sh_used[victim] = tick;
      return 1'b0;
    endfunction

    function int choose_way(int s);
      int victim;
      logic [TS_W-1:0] oldest;
      victim = 0;
      for (int w = 0; w < NWAYS; w++)
        if (!way_ok[s][w]) return w;
      if (policy == POL_FIFO || policy == POL_LRU) begin
        oldest = (policy == POL_FIFO) ? way_fill[s][0] : way_used[s][0];
        for (int w = 1; w < NWAYS; w++) begin
          if (policy == POL_FIFO && way_fill[s][w] < oldest) begin
            oldest = way_fill[s][w];
            victim = w;
          end else if (policy == POL_LRU && way_used[s][w] < oldest) begin
            oldest = way_used[s][w];
            victim = w;
          end
        end
        return victim;
      end
      // galois step, right shift
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
      return int'(lfsr % NWAYS);
    endfunction

    function void note_request(logic [AW-1:0] addr);
      logic [AW-1:0] blk;
      int s, hit_way, v;
      bit fresh, in_shadow;
      kind_e kind;
      outcome_t o;
      blk = addr >> offset;
      s = int'(blk % NSETS);
      hit_way = -1;
      tick++;
      bump(0);
      fresh = !seen[blk];
      seen[blk] = 1'b1;
      in_shadow = shadow_lookup(blk);
      for (int w = 0; w < NWAYS; w++)
        if (hit_way < 0 && way_ok[s][w] && way_blk[s][w] == blk) hit_way = w;
      if (hit_way >= 0) begin
        way_used[s][hit_way] = tick;
        kind = KIND_HIT;
      end else begin
        if (fresh) kind = KIND_COMP;
        else if (!in_shadow) kind = KIND_CAP;
        else kind = KIND_CONF;
        v = choose_way(s);
        way_ok[s][v]   = 1'b1;
        way_blk[s][v]  = blk;
        way_fill[s][v] = tick;
        way_used[s][v] = tick;
      end
      bump(int'(kind) + 1);
      o.kind = kind;
      o.total = stats[0];
      o.hits = stats[1];
      o.compulsory = stats[2];
      o.capacity = stats[3];
      o.conflict = stats[4];
      pending_q.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit   no_idle, hold_rsp;
  int unsigned cycles;
  miss_scoreboard sb;

  cmc_req_if #(.ADDR_BITS(AW)) req_if ();
  cmc_rsp_if rsp_if ();

  cache_miss_classifier_3c uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cache_miss_classifier_3c verification failed");
      $finish;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    outcome_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.kind = kind_e'(rsp_if.access_kind);
      got.total = rsp_if.total_count;
      got.hits = rsp_if.hit_count;
      got.compulsory = rsp_if.compulsory_count;
      got.capacity = rsp_if.capacity_count;
      got.conflict = rsp_if.conflict_count;
      sb.check_result(got);
    end
  end

  // result-side back-pressure: random bursts, one long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_rsp = 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        rsp_if.ready <= 1'b1;
        n = no_idle ? 1 : $urandom_range(1, 10);
        repeat (n) @(negedge clk);
      end else begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
    end
  end

  // drive one request; called at a falling edge, returns at a falling edge
  task automatic send_request(logic [AW-1:0] addr);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.address <= addr;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(addr);
    @(negedge clk);
  endtask

  // register writes only once every result has come back
  task automatic write_config(logic [POL_W-1:0] pol, logic [OFS_W-1:0] ofs);
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (REQ_LAT) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_POLICY;
    cfg_data <= CFG_DATA_W'(pol);
    @(negedge clk);
    cfg_idx  <= CFG_OFFSET;
    cfg_data <= CFG_DATA_W'(ofs);
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.policy = pol;
    sb.offset = ofs;
  endtask

  initial begin
    logic [AW-1:0] pool[80];
    logic [POL_W-1:0] pols[6];
    logic [OFS_W-1:0] ofss[6];
    logic [AW-1:0] a;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    no_idle = 1'b0;
    hold_rsp = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_POLICY;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.address = '0;
    rsp_if.ready = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at reset settings (lru, 16-byte blocks)
    send_request('0);                  // compulsory
    send_request('1);                  // top address
    send_request(16'h0004);            // hit, same block
    send_request(16'h5555);
    send_request(16'hAAAA);
    // fill set zero past its ways, then revisit the evicted block: conflict
    send_request(16'h0100);
    send_request(16'h0200);
    send_request(16'h0300);
    send_request(16'h0400);
    send_request(16'h0000);
    send_request(16'h0100);
    // fifo with ties in fill order, then random eviction in one set
    write_config(POL_FIFO, 4'd4);
    send_request(16'h0500);
    send_request(16'h0000);
    write_config(POL_RAND, 4'd4);
    send_request(16'h0600);
    send_request(16'h0700);
    send_request(16'h0800);
    // widest shift: only two blocks exist; no shift at all
    write_config(POL_UNUSED, 4'd15);
    send_request(16'h8000);
    send_request(16'h7FFF);
    send_request(16'hFFFF);
    write_config(POL_LRU, 4'd0);
    send_request(16'h0010);
    send_request(16'h0011);

    // random part: a reused working set yields hits, conflicts and capacity misses
    pols = '{POL_FIFO, POL_RAND, POL_UNUSED, POL_LRU, POL_FIFO, POL_RAND};
    ofss = '{4'd0, 4'd8, 4'd15, 4'd2, 4'd6, 4'd4};
    for (int p = 0; p < 6; p++) begin
      write_config(pols[p], ofss[p]);
      foreach (pool[i]) pool[i] = AW'($urandom);
      if (p == 1) hold_rsp = 1'b1;     // receiver stalls long while requests keep coming
      if (p == 5) no_idle = 1'b1;
      for (int k = 0; k < 64; k++) begin
        if ($urandom_range(0, 3) == 0)
          a = AW'($urandom);
        else
          a = pool[$urandom_range(0, 20 + p * 10)] ^ AW'($urandom_range(0, 15));
        send_request(a);
      end
    end

    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (REQ_LAT) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("cache_miss_classifier_3c verification clean");
    end else begin
      $display("cache_miss_classifier_3c verification failed");
    end
    $finish;
  end

endmodule
